// ===== design/nbv_pkg.sv =====
// Shared constants and types for the nonprinting byte visualizer.
package nbv_pkg;

  localparam int unsigned SEQ_MAX = 4;
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);
  localparam int unsigned IDX_W   = $clog2(SEQ_MAX);

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_NONPRINT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TABS     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENDS     = 2'd2;

  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_CAP_I  = 8'h49;
  localparam logic [7:0] CH_CAP_M  = 8'h4D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CARET_OFS = 8'd64;
  localparam logic [7:0] META_BIT  = 8'd128;
  localparam logic [7:0] META_CTRL_END    = 8'd159;
  localparam logic [7:0] META_PRINT_START = 8'd160;
  localparam logic [7:0] CH_FF     = 8'd255;

  // One classified input: up to four output bytes, first in slot 0.
  typedef struct packed {
    logic [SEQ_MAX-1:0][7:0] seq;
    logic [IDX_W-1:0]        last_idx;
  } entry_t;

endpackage

// ===== design/nbv_if.sv =====
// Valid/ready channel interfaces for the input and output words.
interface nbv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_line;

  modport source (output valid, output in_byte, output end_of_line, input ready);
  modport sink (input valid, input in_byte, input end_of_line, output ready);
endinterface

interface nbv_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ===== design/nbv_front.sv =====
// Front end: mode registers, input acceptance and expansion of each byte.
module nbv_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [nbv_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [nbv_pkg::CFG_DATA_W-1:0]   cfg_data,
  nbv_in_if.sink                           in_ch,
  input  logic                             full,
  output logic                             push,
  output nbv_pkg::entry_t                  entry
);

  logic mode_nonprint;
  logic mode_tabs;
  logic mode_ends;

  logic [7:0] b;
  logic       eol;
  logic       line_nl;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_nonprint <= 1'b0;
      mode_tabs     <= 1'b0;
      mode_ends     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        nbv_pkg::CFG_NONPRINT: mode_nonprint <= cfg_data[0];
        nbv_pkg::CFG_TABS:     mode_tabs     <= cfg_data[0];
        nbv_pkg::CFG_ENDS:     mode_ends     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;

  assign b       = in_ch.in_byte;
  assign eol     = in_ch.end_of_line;
  assign line_nl = eol && (b == nbv_pkg::CH_NL);

  always_comb begin
    entry = '0;
    if (mode_nonprint) begin
      if (line_nl) begin
        if (mode_ends) begin
          entry.seq[0]   = nbv_pkg::CH_DOLLAR;
          entry.seq[1]   = nbv_pkg::CH_NL;
          entry.last_idx = 2'd1;
        end else begin
          entry.seq[0] = nbv_pkg::CH_NL;
        end
      end else if (mode_tabs && b == nbv_pkg::CH_TAB) begin
        entry.seq[0]   = nbv_pkg::CH_CARET;
        entry.seq[1]   = nbv_pkg::CH_CAP_I;
        entry.last_idx = 2'd1;
      end else if (b == nbv_pkg::CH_NL || b == nbv_pkg::CH_TAB) begin
        entry.seq[0] = b;
      end else if (b < nbv_pkg::CH_SPACE) begin
        entry.seq[0]   = nbv_pkg::CH_CARET;
        entry.seq[1]   = b + nbv_pkg::CARET_OFS;
        entry.last_idx = 2'd1;
      end else if (b == nbv_pkg::CH_DEL) begin
        entry.seq[0]   = nbv_pkg::CH_CARET;
        entry.seq[1]   = nbv_pkg::CH_QMARK;
        entry.last_idx = 2'd1;
      end else if (b >= nbv_pkg::META_BIT && b <= nbv_pkg::META_CTRL_END) begin
        entry.seq[0]   = nbv_pkg::CH_CAP_M;
        entry.seq[1]   = nbv_pkg::CH_DASH;
        entry.seq[2]   = nbv_pkg::CH_CARET;
        entry.seq[3]   = b - nbv_pkg::META_BIT + nbv_pkg::CARET_OFS;
        entry.last_idx = 2'd3;
      end else if (b == nbv_pkg::CH_FF) begin
        entry.seq[0]   = nbv_pkg::CH_CAP_M;
        entry.seq[1]   = nbv_pkg::CH_DASH;
        entry.seq[2]   = nbv_pkg::CH_CARET;
        entry.seq[3]   = nbv_pkg::CH_QMARK;
        entry.last_idx = 2'd3;
      end else if (b >= nbv_pkg::META_PRINT_START) begin
        entry.seq[0]   = nbv_pkg::CH_CAP_M;
        entry.seq[1]   = nbv_pkg::CH_DASH;
        entry.seq[2]   = b - nbv_pkg::META_BIT;
        entry.last_idx = 2'd2;
      end else begin
        entry.seq[0] = b;
      end
    end else if (mode_tabs) begin
      // Tabs-only mode leaves line ends alone, whatever the ends bit says.
      if (b == nbv_pkg::CH_TAB) begin
        entry.seq[0]   = nbv_pkg::CH_CARET;
        entry.seq[1]   = nbv_pkg::CH_CAP_I;
        entry.last_idx = 2'd1;
      end else begin
        entry.seq[0] = b;
      end
    end else if (mode_ends && line_nl) begin
      entry.seq[0]   = nbv_pkg::CH_DOLLAR;
      entry.seq[1]   = nbv_pkg::CH_NL;
      entry.last_idx = 2'd1;
    end else begin
      entry.seq[0] = b;
      if (eol && b != nbv_pkg::CH_NL) begin
        entry.seq[1]   = nbv_pkg::CH_NL;
        entry.last_idx = 2'd1;
      end
    end
  end

endmodule

// ===== design/nbv_queue.sv =====
// Short queue of expanded entries between the front and back ends.
module nbv_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  nbv_pkg::entry_t             push_entry,
  input  logic                        pop,
  output logic                        full,
  output logic                        empty,
  output nbv_pkg::entry_t             head
);

  nbv_pkg::entry_t mem [nbv_pkg::QDEPTH];

  logic [nbv_pkg::QPTR_W-1:0] wr_ptr;
  logic [nbv_pkg::QPTR_W-1:0] rd_ptr;
  logic [nbv_pkg::QCNT_W-1:0] count;

  assign full  = (count == nbv_pkg::QCNT_W'(nbv_pkg::QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == nbv_pkg::QPTR_W'(nbv_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == nbv_pkg::QPTR_W'(nbv_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= nbv_pkg::QCNT_W'(nbv_pkg::QDEPTH))
    else $error("queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow a push");

endmodule

// ===== design/nbv_back.sv =====
// Back end: sends the bytes of each queued entry one word per cycle while the receiver is ready.
module nbv_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        empty,
  input  nbv_pkg::entry_t             head,
  output logic                        pop,
  nbv_out_if.source                   out_ch
);

  logic [nbv_pkg::IDX_W-1:0] idx;
  logic                      load;
  logic                      at_last;

  assign load    = !out_ch.valid || out_ch.ready;
  assign at_last = (idx == head.last_idx);
  assign pop     = load && !empty && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
      idx          <= '0;
    end else if (load) begin
      out_ch.valid <= !empty;
      if (!empty) begin
        idx <= at_last ? '0 : idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      out_ch.out_byte    <= head.seq[idx];
      out_ch.last_of_run <= at_last;
    end
  end

  a_idx_reset_on_pop: assert property (@(posedge clk) disable iff (rst)
    pop |=> (idx == '0))
    else $error("byte index not cleared after an entry");

  a_last_with_pop: assert property (@(posedge clk) disable iff (rst)
    (load && !empty) |=> (out_ch.last_of_run == $past(pop)))
    else $error("last_of_run does not match the entry boundary");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (idx <= head.last_idx))
    else $error("byte index past the end of the entry");

endmodule

// ===== design/nonprinting_byte_visualizer.sv =====
// Top level of the nonprinting byte visualizer.
// Each input word is one text byte with a mark on the last byte of its line; it becomes
// one to four output words in caret and M- notation according to the three mode
// registers (index 0 nonprinting, 1 tabs, 2 ends; only bit 0 of the data is used).
// The front end takes a byte every cycle while its two-entry queue has room, and the
// output stage sends one word per cycle while the receiver is ready, so a byte that
// expands to n words occupies the output for n words and that serialiser sets the
// sustained rate: one input per cycle for plain bytes, and slower for expansions.
// The first output word of an accepted byte is written into the queue and then
// into the output register.
// Mode registers should be written only while the block is idle.
module nonprinting_byte_visualizer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [nbv_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [nbv_pkg::CFG_DATA_W-1:0]   cfg_data,
  nbv_in_if.sink                           in_ch,
  nbv_out_if.source                        out_ch
);

  nbv_pkg::entry_t push_entry;
  nbv_pkg::entry_t head;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;

  nbv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .full      (full),
    .push      (push),
    .entry     (push_entry)
  );

  nbv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .empty      (empty),
    .head       (head)
  );

  nbv_back u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (empty),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ===== sim/nonprinting_byte_visualizer_tb.sv =====
// Self-checking testbench for the nonprinting byte visualizer: directed and random text.
module nonprinting_byte_visualizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Index 3 decodes to no register; a write there must change nothing.
  localparam logic [nbv_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned SHOWN_MAX   = 10;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } vis_word_t;

  class render_scoreboard;
    bit          nonprint;
    bit          tabs;
    bit          ends;
    vis_word_t   pending[$];
    int unsigned failures;

    function void write_reg(logic [nbv_pkg::CFG_INDEX_W-1:0] idx,
                            logic [nbv_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        nbv_pkg::CFG_NONPRINT: nonprint = val[0];
        nbv_pkg::CFG_TABS:     tabs = val[0];
        nbv_pkg::CFG_ENDS:     ends = val[0];
        default: ;
      endcase
    endfunction

    // Expands one text byte into its visible words under the current modes.
    function void note_input(logic [7:0] b, logic eol);
      logic [7:0] seq[$];
      logic       line_nl;
      vis_word_t  word;
      line_nl = eol && (b == nbv_pkg::CH_NL);
      if (nonprint) begin
        if (line_nl) begin
          if (ends) seq.insert(seq.size(), nbv_pkg::CH_DOLLAR);
          seq.insert(seq.size(), nbv_pkg::CH_NL);
        end else if (tabs && b == nbv_pkg::CH_TAB) begin
          seq = '{nbv_pkg::CH_CARET, nbv_pkg::CH_CAP_I};
        end else if (b == nbv_pkg::CH_NL || b == nbv_pkg::CH_TAB) begin
          seq.insert(seq.size(), b);
        end else if (b < nbv_pkg::CH_SPACE) begin
          seq = '{nbv_pkg::CH_CARET, b + nbv_pkg::CARET_OFS};
        end else if (b == nbv_pkg::CH_DEL) begin
          seq = '{nbv_pkg::CH_CARET, nbv_pkg::CH_QMARK};
        end else if (b >= nbv_pkg::META_BIT && b <= nbv_pkg::META_CTRL_END) begin
          seq = '{nbv_pkg::CH_CAP_M, nbv_pkg::CH_DASH, nbv_pkg::CH_CARET,
                  b - nbv_pkg::META_BIT + nbv_pkg::CARET_OFS};
        end else if (b == nbv_pkg::CH_FF) begin
          seq = '{nbv_pkg::CH_CAP_M, nbv_pkg::CH_DASH, nbv_pkg::CH_CARET,
                  nbv_pkg::CH_QMARK};
        end else if (b >= nbv_pkg::META_PRINT_START) begin
          seq = '{nbv_pkg::CH_CAP_M, nbv_pkg::CH_DASH, b - nbv_pkg::META_BIT};
        end else begin
          seq.insert(seq.size(), b);
        end
      end else if (tabs) begin
        // Tabs mode on its own never looks at the ends bit.
        if (b == nbv_pkg::CH_TAB) seq = '{nbv_pkg::CH_CARET, nbv_pkg::CH_CAP_I};
        else seq.insert(seq.size(), b);
      end else if (ends && line_nl) begin
        seq = '{nbv_pkg::CH_DOLLAR, nbv_pkg::CH_NL};
      end else begin
        seq.insert(seq.size(), b);
        if (eol && b != nbv_pkg::CH_NL) seq.insert(seq.size(), nbv_pkg::CH_NL);
      end
      foreach (seq[k]) begin
        word.b = seq[k];
        word.last = (k == seq.size() - 1);
        pending.insert(pending.size(), word);
      end
    endfunction

    function void check_result(logic [7:0] b, logic last);
      vis_word_t want;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= SHOWN_MAX)
          $display("unexpected word: byte %02h last %0b", b, last);
        return;
      end
      want = pending.pop_front();
      if (want.b !== b || want.last !== last) begin
        failures++;
        if (failures <= SHOWN_MAX)
          $display("word mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                   want.b, want.last, b, last);
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [nbv_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [nbv_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  nbv_in_if  in_ch ();
  nbv_out_if out_ch ();

  nonprinting_byte_visualizer uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  render_scoreboard render_sb;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      hold_requests = 0;
  int unsigned      hold_served = 0;
  int unsigned      hold_left = 0;
  int unsigned      quiet_cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    in_ch.end_of_line = 1'b0;
    out_ch.ready = 1'b0;
  end

  always #5 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready)
        render_sb.check_result(out_ch.out_byte, out_ch.last_of_run);
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  task automatic send_word(input logic [7:0] b, input logic eol);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.end_of_line <= eol;
    do @(posedge clk); while (!in_ch.ready);
    render_sb.note_input(b, eol);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (render_sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [nbv_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [nbv_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    render_sb.write_reg(idx, val);
  endtask

  task automatic set_modes(input bit np, input bit tb, input bit en, input bit poke_spare);
    drain();
    write_reg(nbv_pkg::CFG_NONPRINT, np);
    write_reg(nbv_pkg::CFG_TABS, tb);
    write_reg(nbv_pkg::CFG_ENDS, en);
    if (poke_spare) write_reg(CFG_SPARE, 1'b1);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_special();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return nbv_pkg::CH_TAB;
      2:       return nbv_pkg::CH_NL;
      3:       return nbv_pkg::CH_SPACE - 8'd1;
      4:       return nbv_pkg::CH_SPACE;
      5:       return nbv_pkg::CH_DEL;
      6:       return nbv_pkg::META_BIT;
      7:       return nbv_pkg::META_CTRL_END;
      8:       return nbv_pkg::META_PRINT_START;
      default: return nbv_pkg::CH_FF;
    endcase
  endfunction

  // Whole lines of random text, most of them closed by a newline.
  task automatic send_lines(input int unsigned count);
    int unsigned sent;
    int unsigned len;
    logic [7:0]  b;
    logic        eol;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(1, 8);
      for (int unsigned k = 1; k <= len; k++) begin
        eol = (k == len);
        if (eol && $urandom_range(99) < 75) b = nbv_pkg::CH_NL;
        else if ($urandom_range(99) < 30) b = pick_special();
        else b = 8'($urandom_range(255));
        send_word(b, eol);
      end
      sent += len;
    end
  endtask

  initial begin
    render_sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    set_modes(1'b1, 1'b1, 1'b1, 1'b0);
    send_word(8'd0, 1'b0);
    send_word(nbv_pkg::CH_TAB, 1'b0);
    send_word(nbv_pkg::CH_NL, 1'b0);
    send_word(8'd31, 1'b0);
    send_word(nbv_pkg::CH_SPACE, 1'b0);
    send_word(8'd126, 1'b0);
    send_word(nbv_pkg::CH_DEL, 1'b0);
    send_word(nbv_pkg::META_BIT, 1'b0);
    send_word(nbv_pkg::META_CTRL_END, 1'b0);
    send_word(nbv_pkg::META_PRINT_START, 1'b0);
    send_word(8'd254, 1'b0);
    send_word(nbv_pkg::CH_FF, 1'b0);
    send_word(8'h41, 1'b1);
    send_word(nbv_pkg::CH_NL, 1'b1);
    set_modes(1'b1, 1'b0, 1'b0, 1'b0);
    send_word(nbv_pkg::CH_TAB, 1'b0);
    send_word(nbv_pkg::CH_NL, 1'b1);
    set_modes(1'b0, 1'b0, 1'b0, 1'b0);
    send_word(8'd0, 1'b0);
    send_word(8'h78, 1'b1);
    send_word(nbv_pkg::CH_NL, 1'b1);
    send_word(nbv_pkg::CH_FF, 1'b1);
    set_modes(1'b0, 1'b1, 1'b1, 1'b0);
    send_word(nbv_pkg::CH_TAB, 1'b1);
    send_word(nbv_pkg::CH_NL, 1'b1);
    send_word(8'h41, 1'b1);
    set_modes(1'b0, 1'b0, 1'b1, 1'b0);
    send_word(nbv_pkg::CH_NL, 1'b1);
    send_word(nbv_pkg::CH_NL, 1'b0);
    send_word(8'h41, 1'b1);

    for (int unsigned p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      set_modes(p[0], p[1], p[2], p == 6);
      // Long receiver hold-off while the sender keeps offering words.
      if (p == 4) hold_requests++;
      send_lines(5);
      if (p == 5) drain();
      send_lines(5);
    end

    drain();
    repeat (8) @(posedge clk);
    if (render_sb.failures == 0 && render_sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/nbv_pkg.sv
design/nbv_if.sv
design/nbv_front.sv
design/nbv_queue.sv
design/nbv_back.sv
design/nonprinting_byte_visualizer.sv
sim/nonprinting_byte_visualizer_tb.sv
